FILE: src/ast_pkg.sv
package ast_pkg;

   localparam int DEPTH = 128;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int PW    = (CW > 8) ? CW : 8;
   localparam int DW    = 32;

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_PEEK   = 2'd2;
   localparam logic [1:0] CMD_REMOVE = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_BADPOS = 2'd3;

   localparam logic [DW-1:0] NO_VALUE = {DW{1'b1}};

   typedef struct packed {
      logic          wr_en;
      logic [AW-1:0] wr_addr;
      logic [DW-1:0] wr_data;
      logic          rd_en;
      logic [AW-1:0] rd_addr;
   } mem_req_type;

endpackage

FILE: src/ast_ctrl.sv
module ast_ctrl
   import ast_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_push_value,
   input  logic [7:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_entry_count,
   output mem_req_type        mem_req,
   input  logic [DW-1:0]      mem_rd_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PEEK  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_count_ff, rsp_count_in;
   logic          load;
   logic          fire;
   logic [PW-1:0] pos_ext;
   logic [PW-1:0] count_ext;
   logic [PW-1:0] start_ext;
   logic [AW-1:0] start_idx;
   logic [CW:0]   next_rd_ext;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign fire      = req_valid && req_ready;

   assign pos_ext     = PW'(req_position);
   assign count_ext   = PW'(count_ff);
   assign start_ext   = count_ext - pos_ext;
   assign start_idx   = start_ext[AW-1:0];
   assign next_rd_ext = (CW+1)'(wr_idx_ff) + (CW+1)'(2);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      wr_idx_in     = wr_idx_ff;
      load          = 1'b0;
      rsp_value_in  = NO_VALUE;
      rsp_status_in = STAT_OK;
      mem_req       = '0;

      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               case (req_command)
                  CMD_PUSH: begin
                     load = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[AW-1:0];
                        mem_req.wr_data = $unsigned(req_push_value);
                        count_in        = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_PEEK: begin
                     if (count_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = AW'(count_ff - 1'b1);
                        state_in        = S_PEEK;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else if (req_position == 8'd0 || pos_ext > count_ext) begin
                        load          = 1'b1;
                        rsp_status_in = STAT_BADPOS;
                     end else if (req_position == 8'd1) begin
                        load     = 1'b1;
                        count_in = count_ff - 1'b1;
                     end else begin
                        // fetch the entry just above the removed slot
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = start_idx + 1'b1;
                        wr_idx_in       = start_idx;
                        state_in        = S_SHIFT;
                     end
                  end
               endcase
            end
         end
         S_PEEK: begin
            load         = 1'b1;
            rsp_value_in = mem_rd_data;
            state_in     = S_IDLE;
         end
         S_SHIFT: begin
            // move one entry down a slot each cycle, read one ahead
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wr_idx_ff;
            mem_req.wr_data = mem_rd_data;
            if (next_rd_ext < (CW+1)'(count_ff)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = next_rd_ext[AW-1:0];
               wr_idx_in       = wr_idx_ff + 1'b1;
            end else begin
               load     = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = 8'(count_in);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff <= wr_idx_in;
      if (load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = $signed(rsp_value_ff);
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: src/array_stack_with_positional_remove.sv
// Channel  | Handshake            | Payload
// req      | req_valid/req_ready  | req_command, req_push_value, req_position
// rsp      | rsp_valid/rsp_ready  | rsp_read_value, rsp_status, rsp_entry_count
//
// Push, pop and failed commands answer from the idle state; a peek waits for one
// memory read. Removing position n from the top moves the n-1 entries above it down
// a slot, one per cycle via the single memory write port. One item is worked on at a time.
// Reset clears the entry count; the entry memory is not cleared.
// The result register holds a beat while rsp_ready is low and stalls new requests.
module array_stack_with_positional_remove
   import ast_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_push_value,
   input  logic [7:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_entry_count
);

   logic [DW-1:0] entries [DEPTH];
   logic [DW-1:0] rd_data_ff;
   mem_req_type   mem_req;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entries[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entries[mem_req.rd_addr];
      end
   end

   ast_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .mem_req         (mem_req),
      .mem_rd_data     (rd_data_ff)
   );

endmodule
